FILE: src/cpvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpvp_pkg
// Types and fixed constants of the cascaded position/velocity PID block.
// ----------------------------------------------------------------------------
package cpvp_pkg;

  // Gains are signed Q16.16
  localparam int GAIN_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIMIT_W   = 15;
  localparam int RESULT_W  = 16;
  localparam int SUM_W     = 64;

  // Gain is consumed one radix-16 digit per cycle
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = GAIN_W / DIGIT_W;
  localparam int DCNT_W  = $clog2(DIGITS);

  // Integrator clamps and storage widths
  localparam int POS_INTEG_LIM = 1000;
  localparam int VEL_INTEG_LIM = 4000;
  localparam int POS_INTEG_W   = 11;
  localparam int VEL_INTEG_W   = 13;

  // Configuration register map, index = paddr / 4
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam logic [2:0] REG_POS_KP        = 3'd0;
  localparam logic [2:0] REG_POS_KI        = 3'd1;
  localparam logic [2:0] REG_POS_KD        = 3'd2;
  localparam logic [2:0] REG_VEL_KP        = 3'd3;
  localparam logic [2:0] REG_VEL_KI        = 3'd4;
  localparam logic [2:0] REG_VEL_KD        = 3'd5;
  localparam logic [2:0] REG_POS_OUT_LIMIT = 3'd6;
  localparam logic [2:0] REG_VEL_OUT_LIMIT = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_UPD,
    ST_MLOAD,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_PUSH
  } cpvp_state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } cpvp_term_t;

endpackage : cpvp_pkg
`default_nettype wire

FILE: src/cascaded_position_velocity_pid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pid
// One axis of a cascaded position/velocity PID controller, digit-serial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request per control tick:
//   target position, measured position and measured velocity. The result
//   channel (out_valid / out_stall) returns the clamped velocity reference
//   and the clamped drive command for that tick.
//   Gains and output limits are written over the APB port only while the
//   block is idle, a rule for the user that the block does not enforce.
//   The configuration registers and the loop state (previous errors,
//   integrators) clear at reset, and in_stall stays high while reset is
//   asserted. Requests are taken only in idle, after the last result is
//   registered. Each loop runs error, update and clamp steps; the single
//   shared multiplier forms six gain products per tick, each consuming the
//   32-bit gain one 4-bit digit per cycle between a load and an accumulate
//   step. The result sits in an output register; while the receiver stalls
//   it is held and the block still takes the next request, stopping only
//   when it has a new result and the old one has not been taken.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_pid #(
  parameter int POSITION_WIDTH = 20,
  parameter int VELOCITY_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [POSITION_WIDTH-1:0]      in_target_position,
  input  wire logic signed [POSITION_WIDTH-1:0]      in_measured_position,
  input  wire logic signed [VELOCITY_WIDTH-1:0]      in_measured_velocity,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [cpvp_pkg::RESULT_W-1:0]       out_velocity_reference,
  output logic signed [cpvp_pkg::RESULT_W-1:0]       out_drive_command,
  // configuration
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [cpvp_pkg::ADDR_W-1:0]           paddr,
  input  wire logic [cpvp_pkg::DATA_W-1:0]           pwdata,
  output logic [cpvp_pkg::DATA_W-1:0]                prdata,
  output logic                                       pready
);
  import cpvp_pkg::*;

  // Error widths: position error, velocity error, shared operand (diff)
  localparam int EPW = POSITION_WIDTH + 1;
  localparam int EVW = (VELOCITY_WIDTH + 1 > RESULT_W + 1) ? VELOCITY_WIDTH + 1
                                                            : RESULT_W + 1;
  localparam int OPW = ((EPW > EVW) ? EPW : EVW) + 1;
  // Multiplier high accumulator, full product, saturation working width
  localparam int HW  = OPW + DIGIT_W + 1;
  localparam int PRW = HW + GAIN_W;
  localparam int XW  = (PRW > SUM_W) ? PRW : SUM_W;

  localparam logic signed [XW-1:0] SAT_POS = {{(XW-62){1'b0}}, 1'b1, 61'd0};
  localparam logic signed [XW-1:0] SAT_NEG = -SAT_POS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0]  pos_kp_r, pos_ki_r, pos_kd_r;
  logic signed [GAIN_W-1:0]  vel_kp_r, vel_ki_r, vel_kd_r;
  logic        [LIMIT_W-1:0] pos_lim_r, vel_lim_r;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_kp_r  <= '0;
      pos_ki_r  <= '0;
      pos_kd_r  <= '0;
      vel_kp_r  <= '0;
      vel_ki_r  <= '0;
      vel_kd_r  <= '0;
      pos_lim_r <= '0;
      vel_lim_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POS_KP:        pos_kp_r  <= pwdata;
        REG_POS_KI:        pos_ki_r  <= pwdata;
        REG_POS_KD:        pos_kd_r  <= pwdata;
        REG_VEL_KP:        vel_kp_r  <= pwdata;
        REG_VEL_KI:        vel_ki_r  <= pwdata;
        REG_VEL_KD:        vel_kd_r  <= pwdata;
        REG_POS_OUT_LIMIT: pos_lim_r <= pwdata[LIMIT_W-1:0];
        REG_VEL_OUT_LIMIT: vel_lim_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POS_KP:        prdata = pos_kp_r;
      REG_POS_KI:        prdata = pos_ki_r;
      REG_POS_KD:        prdata = pos_kd_r;
      REG_VEL_KP:        prdata = vel_kp_r;
      REG_VEL_KI:        prdata = vel_ki_r;
      REG_VEL_KD:        prdata = vel_kd_r;
      REG_POS_OUT_LIMIT: prdata = DATA_W'(pos_lim_r);
      REG_VEL_OUT_LIMIT: prdata = DATA_W'(vel_lim_r);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  cpvp_state_t state_r, state_nxt;
  cpvp_term_t  pidx_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              loop_r;        // 0: position loop, 1: velocity loop
  logic              out_valid_r;
  logic              accept;
  logic              push;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_MLOAD;
      ST_MLOAD: state_nxt = ST_MUL;
      ST_MUL:   if (dcnt_r == DCNT_W'(DIGITS - 1)) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (pidx_r == TERM_D) ? ST_CLAMP : ST_MLOAD;
      ST_CLAMP: state_nxt = loop_r ? ST_PUSH : ST_ERR;
      ST_PUSH:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    // hold off requests while reset is asserted
    in_stall = !rst_n || (state_r != ST_IDLE);
    accept   = in_valid && !in_stall;
    push     = (state_r == ST_PUSH) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [POSITION_WIDTH-1:0] tgt_r, mpos_r;
  logic signed [VELOCITY_WIDTH-1:0] mvel_r;
  logic signed [OPW-1:0]            err_r, diff_r;
  logic signed [EPW-1:0]            pos_prev_r;
  logic signed [EVW-1:0]            vel_prev_r;
  logic signed [POS_INTEG_W-1:0]    pos_integ_r;
  logic signed [VEL_INTEG_W-1:0]    vel_integ_r;
  logic signed [OPW-1:0]            mul_x_r;
  logic        [GAIN_W-1:0]         gain_sr_r;
  logic signed [HW-1:0]             mul_h_r;
  logic        [GAIN_W-1:0]         mul_l_r;
  logic signed [SUM_W-1:0]          sum_r;
  logic signed [RESULT_W-1:0]       vref_r, drive_r;
  logic signed [RESULT_W-1:0]       out_vref_r, out_drive_r;

  logic signed [EPW-1:0]    pos_err;
  logic signed [EVW-1:0]    vel_err;
  logic signed [OPW-1:0]    prev_ext, integ_ext, diff_calc;
  logic signed [OPW:0]      integ_sum, ilim, integ_clamp;
  logic signed [OPW-1:0]    op_sel;
  logic signed [GAIN_W-1:0] gain_sel;
  logic signed [DIGIT_W:0]  digit;
  logic signed [HW-1:0]     pp, step_sum;
  logic signed [PRW-1:0]    prod;
  logic signed [XW-1:0]     prod_x, prod_sat;
  logic signed [SUM_W-1:0]  sum_shr, lim_ext, res_clamp;

  always_comb begin
    pos_err   = EPW'(tgt_r) - EPW'(mpos_r);
    vel_err   = EVW'(vref_r) - EVW'(mvel_r);
    prev_ext  = loop_r ? OPW'(vel_prev_r) : OPW'(pos_prev_r);
    integ_ext = loop_r ? OPW'(vel_integ_r) : OPW'(pos_integ_r);
    diff_calc = err_r - prev_ext;

    // integrator with symmetric clamp
    integ_sum = (OPW+1)'(integ_ext) + (OPW+1)'(err_r);
    ilim      = loop_r ? (OPW+1)'(VEL_INTEG_LIM) : (OPW+1)'(POS_INTEG_LIM);
    if (integ_sum > ilim)       integ_clamp = ilim;
    else if (integ_sum < -ilim) integ_clamp = -ilim;
    else                        integ_clamp = integ_sum;

    case (pidx_r)
      TERM_P:  op_sel = err_r;
      TERM_I:  op_sel = integ_ext;
      TERM_D:  op_sel = diff_r;
      default: op_sel = err_r;
    endcase

    case ({loop_r, pidx_r})
      {1'b0, TERM_P}: gain_sel = pos_kp_r;
      {1'b0, TERM_I}: gain_sel = pos_ki_r;
      {1'b0, TERM_D}: gain_sel = pos_kd_r;
      {1'b1, TERM_P}: gain_sel = vel_kp_r;
      {1'b1, TERM_I}: gain_sel = vel_ki_r;
      {1'b1, TERM_D}: gain_sel = vel_kd_r;
      default:        gain_sel = '0;
    endcase

    // top digit of the gain carries the sign
    if (dcnt_r == DCNT_W'(DIGITS - 1))
      digit = $signed({gain_sr_r[DIGIT_W-1], gain_sr_r[DIGIT_W-1:0]});
    else
      digit = $signed({1'b0, gain_sr_r[DIGIT_W-1:0]});
    pp       = mul_x_r * digit;
    step_sum = mul_h_r + pp;

    // saturate the finished product to +-2^61
    prod   = $signed({mul_h_r, mul_l_r});
    prod_x = XW'(prod);
    if (prod_x > SAT_POS)      prod_sat = SAT_POS;
    else if (prod_x < SAT_NEG) prod_sat = SAT_NEG;
    else                       prod_sat = prod_x;

    // floor shift, then symmetric output clamp
    sum_shr = sum_r >>> FRAC_BITS;
    lim_ext = loop_r ? $signed(SUM_W'(vel_lim_r)) : $signed(SUM_W'(pos_lim_r));
    if (sum_shr > lim_ext)       res_clamp = lim_ext;
    else if (sum_shr < -lim_ext) res_clamp = -lim_ext;
    else                         res_clamp = sum_shr;
  end

  // loop state and sequencing counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_prev_r  <= '0;
      pos_integ_r <= '0;
      vel_prev_r  <= '0;
      vel_integ_r <= '0;
      loop_r      <= 1'b0;
      pidx_r      <= TERM_P;
      dcnt_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          loop_r <= 1'b0;
        end
        ST_UPD: begin
          if (loop_r) begin
            vel_prev_r  <= EVW'(err_r);
            vel_integ_r <= VEL_INTEG_W'(integ_clamp);
          end else begin
            pos_prev_r  <= EPW'(err_r);
            pos_integ_r <= POS_INTEG_W'(integ_clamp);
          end
          pidx_r <= TERM_P;
        end
        ST_MLOAD: begin
          dcnt_r <= '0;
        end
        ST_MUL: begin
          dcnt_r <= dcnt_r + 1'b1;
        end
        ST_ACC: begin
          case (pidx_r)
            TERM_P:  pidx_r <= TERM_I;
            TERM_I:  pidx_r <= TERM_D;
            default: pidx_r <= TERM_P;
          endcase
        end
        ST_CLAMP: begin
          loop_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_r  <= in_target_position;
      mpos_r <= in_measured_position;
      mvel_r <= in_measured_velocity;
    end
    case (state_r)
      ST_ERR: begin
        err_r <= loop_r ? OPW'(vel_err) : OPW'(pos_err);
      end
      ST_UPD: begin
        diff_r <= diff_calc;
        sum_r  <= '0;
      end
      ST_MLOAD: begin
        mul_x_r   <= op_sel;
        gain_sr_r <= gain_sel;
        mul_h_r   <= '0;
      end
      ST_MUL: begin
        // retire one digit: low nibble drops into the product low word
        mul_h_r   <= step_sum >>> DIGIT_W;
        mul_l_r   <= {step_sum[DIGIT_W-1:0], mul_l_r[GAIN_W-1:DIGIT_W]};
        gain_sr_r <= gain_sr_r >> DIGIT_W;
      end
      ST_ACC: begin
        sum_r <= sum_r + SUM_W'(prod_sat);
      end
      ST_CLAMP: begin
        if (loop_r) drive_r <= RESULT_W'(res_clamp);
        else        vref_r  <= RESULT_W'(res_clamp);
      end
      default: ;
    endcase
    if (push) begin
      out_vref_r  <= vref_r;
      out_drive_r <= drive_r;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n)                     out_valid_r <= 1'b0;
    else if (push)                  out_valid_r <= 1'b1;
    else if (!out_stall)            out_valid_r <= 1'b0;
  end

  assign out_valid              = out_valid_r;
  assign out_velocity_reference = out_vref_r;
  assign out_drive_command      = out_drive_r;

endmodule : cascaded_position_velocity_pid
`default_nettype wire

FILE: tb/cascaded_position_velocity_pid_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pid_test
// Self-checking bench for one axis of the cascaded position/velocity PID.
// An in-bench predictor tracks gains, limits, previous errors and integrators.
// It computes the velocity reference and drive command of every request the
// block takes and compares them in order with what comes out. Stimulus runs
// directed corner ticks first, then random phases, each under its own gain
// and limit setting, with random idling on both channels but in phase 1.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_pid_test;
  import cpvp_pkg::*;

  localparam int POS_W           = 20;
  localparam int VEL_W           = 16;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 10;
  localparam int TICKS_PER_PHASE = 193;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AT_RESULT  = 700;
  localparam int DRAIN_CYCLES    = 100;

  localparam logic [31:0] GAIN_ONE  = 32'h0001_0000;
  localparam logic [31:0] GAIN_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] GAIN_MIN  = 32'h8000_0000;
  localparam logic [31:0] LIMIT_MAX = 32'd32767;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [RESULT_W-1:0] velocity_reference;
    logic signed [RESULT_W-1:0] drive_command;
  } tick_result_t;

  class drive_predictor;
    longint gain[6];
    longint out_limit[2];
    longint err_prev[2];
    longint integ[2];
    tick_result_t expected_ticks[$];
    int unsigned failures;
    int unsigned results_checked;

    function new();
      foreach (gain[k]) gain[k] = 0;
      foreach (out_limit[k]) begin
        out_limit[k] = 0;
        err_prev[k]  = 0;
        integ[k]     = 0;
      end
      failures        = 0;
      results_checked = 0;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint sat_product(longint g, longint x);
      longint cap;
      cap = longint'(1) << 61;
      return clamp(g * x, -cap, cap);
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_POS_OUT_LIMIT: out_limit[0] = longint'(value[LIMIT_W-1:0]);
        REG_VEL_OUT_LIMIT: out_limit[1] = longint'(value[LIMIT_W-1:0]);
        default:           gain[idx]    = longint'(signed'(value));
      endcase
    endfunction

    // lp 0 is the position loop, lp 1 the velocity loop
    function longint loop_update(int lp, longint err);
      longint diff;
      longint acc;
      longint bound;
      bound = (lp == 0) ? POS_INTEG_LIM : VEL_INTEG_LIM;
      diff = err - err_prev[lp];
      err_prev[lp] = err;
      integ[lp] = clamp(integ[lp] + err, -bound, bound);
      acc = sat_product(gain[3*lp], err) + sat_product(gain[3*lp+1], integ[lp])
          + sat_product(gain[3*lp+2], diff);
      // arithmetic shift floors toward minus infinity
      return clamp(acc >>> FRAC_BITS, -out_limit[lp], out_limit[lp]);
    endfunction

    function void note_request(longint tgt, longint mpos, longint mvel);
      longint vref;
      longint drive;
      tick_result_t r;
      vref  = loop_update(0, tgt - mpos);
      drive = loop_update(1, vref - mvel);
      r.velocity_reference = vref[RESULT_W-1:0];
      r.drive_command      = drive[RESULT_W-1:0];
      expected_ticks.push_back(r);
    endfunction

    function void check_result(logic signed [RESULT_W-1:0] vref,
                               logic signed [RESULT_W-1:0] drive);
      tick_result_t want;
      results_checked++;
      if (expected_ticks.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, velocity_reference %0d drive_command %0d",
                 $time, vref, drive);
        return;
      end
      want = expected_ticks.pop_front();
      if (vref !== want.velocity_reference) begin
        failures++;
        $display("%0t: velocity_reference mismatch, expected %0d, actual %0d",
                 $time, want.velocity_reference, vref);
      end
      if (drive !== want.drive_command) begin
        failures++;
        $display("%0t: drive_command mismatch, expected %0d, actual %0d",
                 $time, want.drive_command, drive);
      end
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [POS_W-1:0]    in_target_position;
  logic signed [POS_W-1:0]    in_measured_position;
  logic signed [VEL_W-1:0]    in_measured_velocity;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [RESULT_W-1:0] out_velocity_reference;
  logic signed [RESULT_W-1:0] out_drive_command;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  bit steady;
  int ticks_sent;
  int settings_loaded;
  int cycle_count;

  drive_predictor predictor = new();

  cascaded_position_velocity_pid #(
    .POSITION_WIDTH(POS_W),
    .VELOCITY_WIDTH(VEL_W)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_target_position    (in_target_position),
    .in_measured_position  (in_measured_position),
    .in_measured_velocity  (in_measured_velocity),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_velocity_reference(out_velocity_reference),
    .out_drive_command     (out_drive_command),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    predictor.write_register(idx, value);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] pkp, pki, pkd, vkp, vki, vkd,
                               input logic [31:0] plim, vlim);
    wait_for_results();
    write_register(REG_POS_KP, pkp);
    write_register(REG_POS_KI, pki);
    write_register(REG_POS_KD, pkd);
    write_register(REG_VEL_KP, vkp);
    write_register(REG_VEL_KI, vki);
    write_register(REG_VEL_KD, vkd);
    write_register(REG_POS_OUT_LIMIT, plim);
    write_register(REG_VEL_OUT_LIMIT, vlim);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [31:0] random_gain();
    int unsigned span;
    logic [31:0] mag;
    span = $urandom_range(1, 31);
    mag  = $urandom & ((32'd1 << span) - 32'd1);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic load_random_setting(input int ph);
    logic [31:0] g[6];
    logic [31:0] plim;
    logic [31:0] vlim;
    foreach (g[k]) g[k] = (ph == 3) ? GAIN_MAX : (ph == 6) ? GAIN_MIN : random_gain();
    plim = (ph % 4 == 0) ? LIMIT_MAX : $urandom_range(0, LIMIT_MAX);
    vlim = (ph == 7) ? 32'd0 : (ph % 4 == 0) ? LIMIT_MAX : $urandom_range(0, LIMIT_MAX);
    apply_setting(g[0], g[1], g[2], g[3], g[4], g[5], plim, vlim);
  endtask

  task automatic send_request(input logic signed [POS_W-1:0] tgt, mpos,
                              input logic signed [VEL_W-1:0] mvel);
    int gap;
    gap = 0;
    // mostly short gaps, now and then a long one so requests land late too
    if (!steady && $urandom_range(0, 99) < 27)
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_target_position   <= tgt;
    in_measured_position <= mpos;
    in_measured_velocity <= mvel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.note_request(tgt, mpos, mvel);
    ticks_sent++;
  endtask

  task automatic send_random_request();
    logic signed [POS_W-1:0] tgt;
    logic signed [POS_W-1:0] mpos;
    logic signed [VEL_W-1:0] mvel;
    tgt = POS_W'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      // tracking tick: keep errors small so integrators move off the clamps
      mpos = POS_W'(tgt + $urandom_range(0, 2400) - 1200);
      mvel = VEL_W'($urandom_range(0, 600) - 300);
    end else begin
      mpos = POS_W'($urandom);
      mvel = VEL_W'($urandom);
    end
    send_request(tgt, mpos, mvel);
  endtask

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        predictor.check_result(out_velocity_reference, out_drive_command);
      // hold off once for a long stretch so the block backs up into its input
      if (!hold_done && predictor.results_checked >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 27);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d ticks outstanding",
             cycle_count, predictor.pending());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_target_position   = '0;
    in_measured_position = '0;
    in_measured_velocity = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    steady               = 1'b0;
    ticks_sent           = 0;
    settings_loaded      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // first ticks after reset see a zero previous error
    apply_setting(GAIN_ONE, 32'h0000_1999, 32'h0000_8000,
                  32'h0002_0000, 32'h0000_0800, 32'hFFFF_C000, LIMIT_MAX, LIMIT_MAX);
    send_request(100, 0, 0);
    send_request(100, 50, 10);
    send_request(POS_MAX, POS_MIN, VEL_MAX);
    send_request(POS_MAX, POS_MIN, VEL_MAX);
    send_request(POS_MIN, POS_MAX, VEL_MIN);
    send_request(POS_MAX, POS_MAX, 0);
    send_request(POS_MIN, POS_MIN, -1);
    send_request(0, POS_MAX, VEL_MAX);
    send_request(0, POS_MIN, VEL_MIN);
    send_request(-1, 0, 1);
    send_request(0, 0, 0);

    // zero limit pins the output at zero
    apply_setting(GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE,
                  32'd0, LIMIT_MAX);
    send_request(5000, -5000, 300);
    send_request(-7000, 2000, -300);
    send_request(POS_MAX, POS_MIN, VEL_MIN);
    apply_setting(GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE,
                  LIMIT_MAX, 32'd0);
    send_request(5000, -5000, 300);
    send_request(-7000, 2000, -300);
    send_request(POS_MIN, POS_MAX, VEL_MAX);

    apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                  LIMIT_MAX, LIMIT_MAX);
    send_request(POS_MAX, POS_MIN, VEL_MIN);
    send_request(POS_MIN, POS_MAX, VEL_MAX);
    apply_setting(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN,
                  LIMIT_MAX, LIMIT_MAX);
    send_request(POS_MAX, POS_MIN, VEL_MIN);
    send_request(POS_MIN, POS_MAX, VEL_MAX);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_random_setting(ph);
      steady = (ph == 1);
      for (int n = 0; n < TICKS_PER_PHASE; n++) send_random_request();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d control ticks over %0d gain and limit settings, %0d mismatches.",
             ticks_sent, settings_loaded, predictor.failures);
    $display("Included zero and full-scale limits, extreme gains and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (predictor.failures == 0 && predictor.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
